// ----- hw/rtl/srms_pkg.sv -----
// Types, codes and reset constants shared by the ramped stepper move sequencer.
package srms_pkg;

    localparam int POS_W   = 10;
    localparam int COUNT_W = 10;
    localparam int DELAY_W = 8;
    localparam int RAMP_W  = 6;
    localparam int PAT_W   = 8;
    localparam int PHASE_W = 2;
    localparam int OP_W    = 2;
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [OP_W-1:0] {
        OP_MOVE = 2'd0,
        OP_TICK = 2'd1,
        OP_HOME = 2'd2
    } opcode_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BASE_DELAY     = 3'd0,
        REG_RAMP_LEN       = 3'd1,
        REG_POSITION_LIMIT = 3'd2,
        REG_PATTERN_ZERO   = 3'd3,
        REG_PATTERN_ONE    = 3'd4,
        REG_PATTERN_TWO    = 3'd5,
        REG_PATTERN_THREE  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [DELAY_W-1:0]          base_delay;
        logic [RAMP_W-1:0]           ramp_len;
        logic [POS_W-1:0]            position_limit;
        logic [3:0][PAT_W-1:0]       pattern;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        base_delay:     8'd20,
        ramp_len:       6'd13,
        position_limit: 10'd200,
        pattern:        {8'h35, 8'h2d, 8'h2e, 8'h36}
    };

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic               direction;
        logic [COUNT_W-1:0] step_count;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] coil_phase;
        logic [POS_W-1:0]   rotor_position;
        logic [COUNT_W-1:0] steps_total;
        logic [COUNT_W-1:0] step_index;
        logic [DELAY_W-1:0] current_delay;
        logic [DELAY_W-1:0] wait_left;
        logic               move_active;
        logic               move_dir;
        logic [PAT_W-1:0]   drive_out;
    } state_t;

    typedef struct packed {
        logic [PAT_W-1:0] coil_pattern;
        logic             busy_res;
        logic [POS_W-1:0] position;
        logic             step_issued;
        logic             move_done;
        logic             rejected;
    } result_t;

endpackage

// ----- hw/rtl/srms_channels.sv -----
// Valid/ready channel interfaces for command items and result items.
interface srms_in_if
    import srms_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic               direction;
    logic [COUNT_W-1:0] step_count;

    modport source (output valid, output opcode, output direction, output step_count,
                    input ready);
    modport sink (input valid, input opcode, input direction, input step_count,
                  output ready);
endinterface

interface srms_out_if
    import srms_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PAT_W-1:0] coil_pattern;
    logic             busy_res;
    logic [POS_W-1:0] position;
    logic             step_issued;
    logic             move_done;
    logic             rejected;

    modport source (output valid, output coil_pattern, output busy_res, output position,
                    output step_issued, output move_done, output rejected, input ready);
    modport sink (input valid, input coil_pattern, input busy_res, input position,
                  input step_issued, input move_done, input rejected, output ready);
endinterface

// ----- hw/rtl/stepper_ramped_move_sequencer.sv -----
// Top level of the ramped full-step stepper move sequencer.
//
//  Channel   Direction  Carries
//  cmd       sink       opcode, direction, step_count
//  res       source     coil_pattern, busy_res, position, step_issued, move_done, rejected
//  cfg_*     write      seven registers, index 0 to 6
//
// Each transaction passes an input register and a result register.
// One transaction is accepted every cycle unless a result stalls; the move state
// updates as the item leaves the input register, so the next item always sees it.
// A stalled result holds in the result register while one more item waits at the input.
// Reset clears the move state, the handshake state and loads the register defaults.
module stepper_ramped_move_sequencer
    import srms_pkg::*;
#(
    parameter int MAX_STEPS = 1023
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    srms_in_if.sink               cmd,
    srms_out_if.source            res
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    fire;
    logic    accept;

    assign advance   = !out_valid_reg || res.ready;
    assign fire      = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_BASE_DELAY:     cfg_next.base_delay = cfg_data[DELAY_W-1:0];
                REG_RAMP_LEN:       cfg_next.ramp_len = cfg_data[RAMP_W-1:0];
                REG_POSITION_LIMIT: cfg_next.position_limit = cfg_data[POS_W-1:0];
                REG_PATTERN_ZERO:   cfg_next.pattern[0] = cfg_data[PAT_W-1:0];
                REG_PATTERN_ONE:    cfg_next.pattern[1] = cfg_data[PAT_W-1:0];
                REG_PATTERN_TWO:    cfg_next.pattern[2] = cfg_data[PAT_W-1:0];
                REG_PATTERN_THREE:  cfg_next.pattern[3] = cfg_data[PAT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    srms_core #(
        .MAX_STEPS (MAX_STEPS)
    ) u_core (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    assign in_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.opcode     <= cmd.opcode;
            item_reg.direction  <= cmd.direction;
            item_reg.step_count <= cmd.step_count;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.coil_pattern = res_reg.coil_pattern;
    assign res.busy_res     = res_reg.busy_res;
    assign res.position     = res_reg.position;
    assign res.step_issued  = res_reg.step_issued;
    assign res.move_done    = res_reg.move_done;
    assign res.rejected     = res_reg.rejected;

    a_issue_or_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.step_issued && res_reg.move_done))
        else $error("A result reports both a step and the end of the move.");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.rejected |-> res_reg.busy_res)
        else $error("A rejected move is reported while the sequencer is idle.");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.move_active |-> state_reg.step_index <= state_reg.steps_total)
        else $error("The step index has passed the step total of the move.");

    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("A waiting transaction left the input register while stalled.");

endmodule

// ----- hw/rtl/srms_core.sv -----
// Combinational update of the move state and result for one command item.
module srms_core
    import srms_pkg::*;
#(
    parameter int MAX_STEPS = 1023
)
(
    input  item_t   item,
    input  state_t  state,
    input  cfg_t    cfg,
    output state_t  state_next,
    output result_t result
);

    localparam int CLIP = (MAX_STEPS > 1023) ? 1023 : MAX_STEPS;
    localparam logic [COUNT_W-1:0] CLIP_COUNT = CLIP[COUNT_W-1:0];
    localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

    function automatic state_t issue_step(input state_t s, input cfg_t c);
        state_t             r;
        logic [POS_W:0]     pos_up;
        logic [DELAY_W-1:0] d;
        logic [COUNT_W-1:0] left;
        r = s;
        pos_up = {1'b0, s.rotor_position} + 1'b1;
        if (!s.move_dir)
        begin
            r.coil_phase = s.coil_phase + 1'b1;
            r.rotor_position = (pos_up > {1'b0, c.position_limit}) ? '0 : pos_up[POS_W-1:0];
        end
        else
        begin
            r.coil_phase = s.coil_phase - 1'b1;
            r.rotor_position = (s.rotor_position == '0) ? c.position_limit
                                                        : s.rotor_position - 1'b1;
        end
        r.drive_out = c.pattern[r.coil_phase];
        r.wait_left = s.current_delay;
        d = s.current_delay;
        if (s.step_index <= {{(COUNT_W-RAMP_W){1'b0}}, c.ramp_len} && d > 8'd1)
        begin
            d = d - 1'b1;
        end
        left = s.steps_total - s.step_index;
        if (left <= {{(COUNT_W-RAMP_W){1'b0}}, c.ramp_len} && d != DELAY_MAX)
        begin
            d = d + 1'b1;
        end
        r.current_delay = d;
        r.step_index = s.step_index + 1'b1;
        return r;
    endfunction

    logic [COUNT_W-1:0] count_sat;
    state_t             start;
    logic               issued;
    logic               done;
    logic               rej;

    assign count_sat = (item.step_count > CLIP_COUNT) ? CLIP_COUNT : item.step_count;

    always_comb
    begin
        start = state;
        start.steps_total = count_sat;
        start.step_index = '0;
        start.move_dir = item.direction;
        start.current_delay = (cfg.base_delay == '0) ? 8'd1 : cfg.base_delay;
        start.move_active = 1'b1;
    end

    always_comb
    begin
        state_next = state;
        issued = 1'b0;
        done = 1'b0;
        rej = 1'b0;
        unique case (item.opcode)
            OP_MOVE:
            begin
                if (state.move_active)
                begin
                    rej = 1'b1;
                end
                else if (count_sat != '0)
                begin
                    state_next = issue_step(start, cfg);
                    issued = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (state.move_active)
                begin
                    if (state.wait_left > 8'd1)
                    begin
                        state_next.wait_left = state.wait_left - 1'b1;
                    end
                    else if (state.step_index < state.steps_total)
                    begin
                        state_next = issue_step(state, cfg);
                        issued = 1'b1;
                    end
                    else
                    begin
                        state_next.wait_left = '0;
                        state_next.move_active = 1'b0;
                        done = 1'b1;
                    end
                end
            end
            OP_HOME:
            begin
                state_next.rotor_position = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign result.coil_pattern = state_next.drive_out;
    assign result.busy_res     = state_next.move_active;
    assign result.position     = state_next.rotor_position;
    assign result.step_issued  = issued;
    assign result.move_done    = done;
    assign result.rejected     = rej;

endmodule
